@@ sv/csvl_pkg.sv @@
// shared types and codes for the count-sorted value list
package csvl_pkg;

  // operation codes carried in the op field
  localparam logic [2:0] OP_APPEND    = 3'd0;
  localparam logic [2:0] OP_DROP      = 3'd1;
  localparam logic [2:0] OP_INCREMENT = 3'd2;
  localparam logic [2:0] OP_DECREMENT = 3'd3;
  localparam logic [2:0] OP_CLEAR     = 3'd4;
  localparam logic [2:0] OP_FIND      = 3'd5;
  localparam logic [2:0] OP_READ      = 3'd6;

  // counter saturation bounds
  localparam logic signed [15:0] CNT_MAX = 16'sh7FFF;
  localparam logic signed [15:0] CNT_MIN = 16'sh8000;

  // one list entry: value and its counter move together
  typedef struct packed {
    logic signed [15:0] value;
    logic signed [15:0] count;
  } entry_t;

  // datapath actions, one per cycle
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_CAPTURE,
    ACT_APPEND,
    ACT_DROP,
    ACT_CLEAR,
    ACT_READ_POS,
    ACT_TAKE_ENTRY,
    ACT_LOAD_HELD,
    ACT_READ_NEXT,
    ACT_READ_PREV,
    ACT_SHIFT_UP,
    ACT_SHIFT_DOWN,
    ACT_PLACE,
    ACT_SCAN_READ,
    ACT_SCAN_FIND,
    ACT_SCAN_MAX
  } dp_act_t;

  // command from controller to datapath
  typedef struct packed {
    dp_act_t act;
    logic    set_ok;
    logic    load_out;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       full;
    logic       empty;
    logic       one_left;
    logic       pos_valid;
    logic       has_next;
    logic       has_prev;
    logic       move_up;
    logic       move_down;
    logic       match;
    logic       scan_last;
  } dp_stat_t;

endpackage

@@ sv/count_sorted_value_list.sv @@
// Count-sorted value list top level: a list of up to DEPTH signed 16-bit
// values, each with a saturating signed 16-bit counter, kept in ascending
// counter order, with append, drop last, clear, increment/decrement and
// re-sort, find and read operations; every result word also carries the
// length and the greatest stored value. One word is worked on at a time; the
// next is taken as soon as the previous result sits in the output register.
// A find scans entries from the front until a match or the end of the list; a
// drop that leaves entries rescans them for the maximum; increment and decrement
// walk the entry past each neighbour that it moves beyond. Each step of a walk
// or scan reads and then checks an entry because the entries sit in a memory
// with registered read data. No clearing pass after reset.
module count_sorted_value_list #(
  parameter int DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // op[2:0], position[9:3], item_value[25:10]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata   // ok[0], found[1], entry_value[17:2],
                                // entry_count[33:18], length[41:34],
                                // largest_value[57:42]
);

  csvl_pkg::dp_cmd_t  cmd;
  csvl_pkg::dp_stat_t stat;

  // operation sequencing
  csvl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage and arithmetic
  csvl_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .m_tdata (m_tdata),
    .cmd     (cmd),
    .stat    (stat)
  );

endmodule

@@ sv/csvl_ctrl.sv @@
// controller state machine: sequences datapath actions for each operation
module csvl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  csvl_pkg::dp_stat_t stat,
  output csvl_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_READ_TAKE,
    S_BUMP,
    S_WALK_RD,
    S_WALK_CHK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   is_inc;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign is_inc   = (stat.op == csvl_pkg::OP_INCREMENT);

  // next state and datapath command
  always_comb begin
    state_next   = state;
    cmd.act      = csvl_pkg::ACT_NONE;
    cmd.set_ok   = 1'b0;
    cmd.load_out = 1'b0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.act    = csvl_pkg::ACT_CAPTURE;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_DONE;
        case (stat.op)
          csvl_pkg::OP_APPEND: begin
            if (!stat.full) begin
              cmd.act    = csvl_pkg::ACT_APPEND;
              cmd.set_ok = 1'b1;
            end
          end
          csvl_pkg::OP_DROP: begin
            if (!stat.empty) begin
              cmd.act    = csvl_pkg::ACT_DROP;
              cmd.set_ok = 1'b1;
              if (!stat.one_left) begin
                state_next = S_SCAN_RD;
              end
            end
          end
          csvl_pkg::OP_CLEAR: begin
            cmd.act    = csvl_pkg::ACT_CLEAR;
            cmd.set_ok = 1'b1;
          end
          csvl_pkg::OP_FIND: begin
            cmd.set_ok = 1'b1;
            if (!stat.empty) begin
              state_next = S_SCAN_RD;
            end
          end
          csvl_pkg::OP_READ: begin
            if (stat.pos_valid) begin
              cmd.act    = csvl_pkg::ACT_READ_POS;
              cmd.set_ok = 1'b1;
              state_next = S_READ_TAKE;
            end
          end
          csvl_pkg::OP_INCREMENT, csvl_pkg::OP_DECREMENT: begin
            if (stat.pos_valid) begin
              cmd.act    = csvl_pkg::ACT_READ_POS;
              cmd.set_ok = 1'b1;
              state_next = S_BUMP;
            end
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_READ_TAKE: begin
        cmd.act    = csvl_pkg::ACT_TAKE_ENTRY;
        state_next = S_DONE;
      end
      S_BUMP: begin
        cmd.act    = csvl_pkg::ACT_LOAD_HELD;
        state_next = S_WALK_RD;
      end
      // fetch the neighbor in the direction of travel, or settle here
      S_WALK_RD: begin
        if (is_inc ? stat.has_next : stat.has_prev) begin
          cmd.act    = is_inc ? csvl_pkg::ACT_READ_NEXT : csvl_pkg::ACT_READ_PREV;
          state_next = S_WALK_CHK;
        end else begin
          cmd.act    = csvl_pkg::ACT_PLACE;
          state_next = S_DONE;
        end
      end
      // move the neighbor into the hole, or drop the held entry here
      S_WALK_CHK: begin
        if (is_inc ? stat.move_up : stat.move_down) begin
          cmd.act    = is_inc ? csvl_pkg::ACT_SHIFT_UP : csvl_pkg::ACT_SHIFT_DOWN;
          state_next = S_WALK_RD;
        end else begin
          cmd.act    = csvl_pkg::ACT_PLACE;
          state_next = S_DONE;
        end
      end
      S_SCAN_RD: begin
        cmd.act    = csvl_pkg::ACT_SCAN_READ;
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (stat.op == csvl_pkg::OP_FIND) begin
          cmd.act    = csvl_pkg::ACT_SCAN_FIND;
          state_next = (stat.match || stat.scan_last) ? S_DONE : S_SCAN_RD;
        end else begin
          cmd.act    = csvl_pkg::ACT_SCAN_MAX;
          state_next = stat.scan_last ? S_DONE : S_SCAN_RD;
        end
      end
      S_DONE: begin
        if (!out_valid || m_tready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // an accepted word always goes to decode next
  a_capture_decode: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == S_DECODE)
    else $error("accepted word not decoded");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && out_valid && !m_tready |=> state == S_DONE && out_valid)
    else $error("pending result overwritten");

  // results are only produced on the way back to idle
  a_load_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> state == S_IDLE && out_valid)
    else $error("result load did not return to idle");

endmodule

@@ sv/csvl_datapath.sv @@
// datapath: entry memory, length, largest value, walk index and result word
module csvl_datapath #(
  parameter int DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [31:0]        s_tdata,
  output logic [63:0]        m_tdata,
  input  csvl_pkg::dp_cmd_t  cmd,
  output csvl_pkg::dp_stat_t stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW = $clog2(DEPTH + 1);
  localparam int CW = (TW > 7) ? TW : 7;
  localparam int LW = (TW > 8) ? TW : 8;

  csvl_pkg::entry_t mem [DEPTH];
  csvl_pkg::entry_t rdata;
  csvl_pkg::entry_t wr_data;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    rd_addr;

  logic [2:0]         op_r;
  logic [6:0]         pos_r;
  logic signed [15:0] val_r;
  logic [TW-1:0]      total;
  logic signed [15:0] largest;
  logic [AW-1:0]      idx;
  logic signed [15:0] held_val;
  logic signed [15:0] held_cnt;
  logic               ok_r;
  logic               found_r;
  logic signed [15:0] ev_r;
  logic signed [15:0] ec_r;

  logic [CW-1:0]      pos_ext;
  logic [CW-1:0]      total_ext;
  logic [CW-1:0]      idx_inc;
  logic [AW-1:0]      pos_ix;
  logic [LW-1:0]      length_ext;
  logic signed [15:0] bumped;

  assign pos_ext    = CW'(pos_r);
  assign total_ext  = CW'(total);
  assign idx_inc    = CW'(idx) + CW'(1);
  assign pos_ix     = pos_ext[AW-1:0];
  assign length_ext = LW'(total);

  // status toward the controller
  always_comb begin
    stat.op        = op_r;
    stat.full      = (total == TW'(DEPTH));
    stat.empty     = (total == '0);
    stat.one_left  = (total == TW'(1));
    stat.pos_valid = (pos_ext < total_ext);
    stat.has_next  = (idx_inc < total_ext);
    stat.has_prev  = (idx != '0);
    stat.move_up   = ($signed(held_cnt) > $signed(rdata.count));
    stat.move_down = ($signed(held_cnt) < $signed(rdata.count));
    stat.match     = (rdata.value == val_r);
    stat.scan_last = (idx_inc == total_ext);
  end

  // saturating counter step for the fetched entry
  always_comb begin
    if (op_r == csvl_pkg::OP_INCREMENT) begin
      bumped = (rdata.count == csvl_pkg::CNT_MAX) ? rdata.count : rdata.count + 16'sd1;
    end else begin
      bumped = (rdata.count == csvl_pkg::CNT_MIN) ? rdata.count : rdata.count - 16'sd1;
    end
  end

  // memory read address
  always_comb begin
    case (cmd.act)
      csvl_pkg::ACT_READ_POS:  rd_addr = pos_ix;
      csvl_pkg::ACT_READ_NEXT: rd_addr = idx + AW'(1);
      csvl_pkg::ACT_READ_PREV: rd_addr = idx - AW'(1);
      default:                 rd_addr = idx;
    endcase
  end

  // memory write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = rdata;
    case (cmd.act)
      csvl_pkg::ACT_APPEND: begin
        wr_en   = 1'b1;
        wr_addr = total[AW-1:0];
        wr_data = '{value: val_r, count: 16'sd0};
      end
      csvl_pkg::ACT_SHIFT_UP, csvl_pkg::ACT_SHIFT_DOWN: begin
        wr_en = 1'b1;
      end
      csvl_pkg::ACT_PLACE: begin
        wr_en   = 1'b1;
        wr_data = '{value: held_val, count: held_cnt};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  // list length and largest value
  always_ff @(posedge clk) begin
    if (rst) begin
      total   <= '0;
      largest <= '0;
    end else begin
      case (cmd.act)
        csvl_pkg::ACT_APPEND: begin
          total <= total + TW'(1);
          if (total == '0 || val_r > largest) begin
            largest <= val_r;
          end
        end
        csvl_pkg::ACT_DROP: begin
          total   <= total - TW'(1);
          largest <= '0;
        end
        csvl_pkg::ACT_CLEAR: begin
          total   <= '0;
          largest <= '0;
        end
        csvl_pkg::ACT_SCAN_MAX: begin
          if (idx == '0 || rdata.value > largest) begin
            largest <= rdata.value;
          end
        end
        default: begin
          largest <= largest;
        end
      endcase
    end
  end

  // operation fields, walk index, held entry and result fields
  always_ff @(posedge clk) begin
    case (cmd.act)
      csvl_pkg::ACT_CAPTURE: begin
        op_r    <= s_tdata[2:0];
        pos_r   <= s_tdata[9:3];
        val_r   <= s_tdata[25:10];
        idx     <= '0;
        ok_r    <= 1'b0;
        found_r <= 1'b0;
        ev_r    <= '0;
        ec_r    <= '0;
      end
      csvl_pkg::ACT_READ_POS: begin
        idx <= pos_ix;
      end
      csvl_pkg::ACT_TAKE_ENTRY: begin
        ev_r <= rdata.value;
        ec_r <= rdata.count;
      end
      csvl_pkg::ACT_LOAD_HELD: begin
        held_val <= rdata.value;
        held_cnt <= bumped;
      end
      csvl_pkg::ACT_SHIFT_UP, csvl_pkg::ACT_SCAN_MAX: begin
        idx <= idx + AW'(1);
      end
      csvl_pkg::ACT_SHIFT_DOWN: begin
        idx <= idx - AW'(1);
      end
      csvl_pkg::ACT_SCAN_FIND: begin
        idx <= idx + AW'(1);
        if (rdata.value == val_r) begin
          found_r <= 1'b1;
        end
      end
      default: begin
        idx <= idx;
      end
    endcase
    if (cmd.set_ok) begin
      ok_r <= 1'b1;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {6'd0, largest, length_ext[7:0], ec_r, ev_r, found_r, ok_r};
    end
  end

  // the length never passes the capacity
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= TW'(DEPTH))
    else $error("length beyond capacity");

  // an append grows the list by exactly one
  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.act == csvl_pkg::ACT_APPEND |=> total == $past(total) + TW'(1))
    else $error("append did not grow the list by one");

  // a clear empties the list and zeroes the largest value
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.act == csvl_pkg::ACT_CLEAR |=> total == '0 && largest == '0)
    else $error("clear left entries or largest value");

endmodule

@@ bench/tb_count_sorted_value_list.sv @@
// testbench for the count-sorted value list: directed table, fill run, random ops
module tb_count_sorted_value_list;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH = 128;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 300;
  localparam int RANDOM_PER_PHASE = 415;
  localparam logic [2:0] OP_UNUSED = 3'd7;

  // one result word, unpacked from m_tdata
  typedef struct packed {
    logic               ok;
    logic               found;
    logic signed [15:0] entry_value;
    logic signed [15:0] entry_count;
    logic [7:0]         length;
    logic signed [15:0] largest_value;
  } list_result_t;

  // one row of the directed table; typed rows carry their own expectation
  typedef struct packed {
    logic [2:0]  op;
    logic [6:0]  pos;
    logic [15:0] val;
    logic        typed;
    logic        ok;
    logic        found;
    logic [7:0]  length;
    logic [15:0] largest;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // op[2:0], position[9:3], item_value[25:10]
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;   // ok[0], found[1], entry_value[17:2], entry_count[33:18],
                          // length[41:34], largest_value[57:42]

  // list as the bench believes it to be
  csvl_pkg::entry_t list_entries [LIST_DEPTH];
  int               list_len;
  list_result_t     pending_results [$];

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;
  int mismatch_count;
  int words_sent;
  int results_seen;

  // directed table: empty list, extremes, range errors, equal counters, negative maximum
  stim_row_t directed_rows [26] = '{
    '{csvl_pkg::OP_READ,      7'd0,   16'h0000, 1'b1, 1'b0, 1'b0, 8'd0, 16'h0000},
    '{csvl_pkg::OP_DROP,      7'd0,   16'h0000, 1'b1, 1'b0, 1'b0, 8'd0, 16'h0000},
    '{csvl_pkg::OP_INCREMENT, 7'd0,   16'h0000, 1'b1, 1'b0, 1'b0, 8'd0, 16'h0000},
    '{csvl_pkg::OP_DECREMENT, 7'd5,   16'h0000, 1'b1, 1'b0, 1'b0, 8'd0, 16'h0000},
    '{csvl_pkg::OP_FIND,      7'd0,   16'h0000, 1'b1, 1'b1, 1'b0, 8'd0, 16'h0000},
    '{OP_UNUSED,              7'd127, 16'hFFFF, 1'b1, 1'b0, 1'b0, 8'd0, 16'h0000},
    '{csvl_pkg::OP_APPEND,    7'd0,   16'h7FFF, 1'b1, 1'b1, 1'b0, 8'd1, 16'h7FFF},
    '{csvl_pkg::OP_APPEND,    7'd0,   16'h8000, 1'b1, 1'b1, 1'b0, 8'd2, 16'h7FFF},
    '{csvl_pkg::OP_APPEND,    7'd0,   16'h0000, 1'b1, 1'b1, 1'b0, 8'd3, 16'h7FFF},
    '{csvl_pkg::OP_INCREMENT, 7'd1,   16'h0000, 1'b0, 1'b0, 1'b0, 8'd0, 16'h0000},
    '{csvl_pkg::OP_INCREMENT, 7'd0,   16'h0000, 1'b0, 1'b0, 1'b0, 8'd0, 16'h0000},
    '{csvl_pkg::OP_DECREMENT, 7'd2,   16'h0000, 1'b0, 1'b0, 1'b0, 8'd0, 16'h0000},
    '{csvl_pkg::OP_DECREMENT, 7'd0,   16'h0000, 1'b0, 1'b0, 1'b0, 8'd0, 16'h0000},
    '{csvl_pkg::OP_READ,      7'd0,   16'h0000, 1'b0, 1'b0, 1'b0, 8'd0, 16'h0000},
    '{csvl_pkg::OP_READ,      7'd1,   16'h0000, 1'b0, 1'b0, 1'b0, 8'd0, 16'h0000},
    '{csvl_pkg::OP_READ,      7'd2,   16'h0000, 1'b0, 1'b0, 1'b0, 8'd0, 16'h0000},
    '{csvl_pkg::OP_READ,      7'd3,   16'h0000, 1'b1, 1'b0, 1'b0, 8'd3, 16'h7FFF},
    '{csvl_pkg::OP_READ,      7'd127, 16'h0000, 1'b1, 1'b0, 1'b0, 8'd3, 16'h7FFF},
    '{csvl_pkg::OP_INCREMENT, 7'd127, 16'h0000, 1'b1, 1'b0, 1'b0, 8'd3, 16'h7FFF},
    '{csvl_pkg::OP_FIND,      7'd0,   16'h8000, 1'b1, 1'b1, 1'b1, 8'd3, 16'h7FFF},
    '{csvl_pkg::OP_FIND,      7'd0,   16'h5555, 1'b1, 1'b1, 1'b0, 8'd3, 16'h7FFF},
    '{OP_UNUSED,              7'd0,   16'h0000, 1'b1, 1'b0, 1'b0, 8'd3, 16'h7FFF},
    '{csvl_pkg::OP_DROP,      7'd0,   16'h0000, 1'b0, 1'b0, 1'b0, 8'd0, 16'h0000},
    '{csvl_pkg::OP_CLEAR,     7'd0,   16'h0000, 1'b1, 1'b1, 1'b0, 8'd0, 16'h0000},
    '{csvl_pkg::OP_APPEND,    7'd0,   16'hAAAA, 1'b1, 1'b1, 1'b0, 8'd1, 16'hAAAA},
    '{csvl_pkg::OP_APPEND,    7'd0,   16'h8000, 1'b1, 1'b1, 1'b0, 8'd2, 16'hAAAA}
  };

  count_sorted_value_list #(
    .DEPTH(LIST_DEPTH)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  // 20 ns clock
  always #10 clk = ~clk;

  // apply one operation to the list and work out its result word
  function automatic list_result_t apply_list_op(logic [2:0] op, logic [6:0] pos,
                                                 logic [15:0] val);
    list_result_t       r;
    csvl_pkg::entry_t   tmp;
    int                 i;
    logic signed [15:0] top;
    r = '0;
    case (op)
      csvl_pkg::OP_APPEND: begin
        if (list_len < LIST_DEPTH) begin
          list_entries[list_len].value = val;
          list_entries[list_len].count = '0;
          list_len++;
          r.ok = 1'b1;
        end
      end
      csvl_pkg::OP_DROP: begin
        if (list_len > 0) begin
          list_len--;
          r.ok = 1'b1;
        end
      end
      csvl_pkg::OP_INCREMENT: begin
        if (pos < list_len) begin
          r.ok = 1'b1;
          if (list_entries[pos].count != csvl_pkg::CNT_MAX)
            list_entries[pos].count = list_entries[pos].count + 16'd1;
          // bubble toward the back past strictly smaller counters
          i = pos;
          while (i + 1 < list_len &&
                 $signed(list_entries[i].count) > $signed(list_entries[i + 1].count)) begin
            tmp = list_entries[i];
            list_entries[i] = list_entries[i + 1];
            list_entries[i + 1] = tmp;
            i++;
          end
        end
      end
      csvl_pkg::OP_DECREMENT: begin
        if (pos < list_len) begin
          r.ok = 1'b1;
          if (list_entries[pos].count != csvl_pkg::CNT_MIN)
            list_entries[pos].count = list_entries[pos].count - 16'd1;
          // bubble toward the front past strictly greater counters
          i = pos;
          while (i > 0 &&
                 $signed(list_entries[i].count) < $signed(list_entries[i - 1].count)) begin
            tmp = list_entries[i];
            list_entries[i] = list_entries[i - 1];
            list_entries[i - 1] = tmp;
            i--;
          end
        end
      end
      csvl_pkg::OP_CLEAR: begin
        list_len = 0;
        r.ok = 1'b1;
      end
      csvl_pkg::OP_FIND: begin
        r.ok = 1'b1;
        for (i = 0; i < list_len; i++)
          if (list_entries[i].value == val) r.found = 1'b1;
      end
      csvl_pkg::OP_READ: begin
        if (pos < list_len) begin
          r.ok = 1'b1;
          r.entry_value = list_entries[pos].value;
          r.entry_count = list_entries[pos].count;
        end
      end
      default: begin
      end
    endcase
    // greatest value over the live entries
    top = '0;
    if (list_len > 0) top = list_entries[0].value;
    for (i = 1; i < list_len; i++)
      if ($signed(list_entries[i].value) > top) top = list_entries[i].value;
    r.length = 8'(list_len);
    r.largest_value = top;
    return r;
  endfunction

  // offer one word, wait for it to be taken, then record what it should produce
  task automatic issue_op(input logic [2:0] op, input logic [6:0] pos,
                          input logic [15:0] val, input logic use_typed = 1'b0,
                          input list_result_t typed_result = '0);
    list_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, val, pos, op};
    do @(posedge clk); while (!s_tready);
    predicted = apply_list_op(op, pos, val);
    pending_results.push_back(use_typed ? typed_result : predicted);
    words_sent++;
    @(negedge clk);
  endtask

  // mostly small values so finds hit, sometimes any 16-bit value
  function automatic logic [15:0] pick_value();
    if ($urandom_range(99) < 60) return 16'($urandom_range(15)) - 16'd8;
    return 16'($urandom_range(65535));
  endfunction

  // random operations in stretches that grow, churn or shrink the list
  task automatic random_ops(input int count);
    int          mode;
    int          roll;
    logic [2:0]  op;
    logic [6:0]  pos;
    logic [15:0] val;
    mode = 0;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) mode = $urandom_range(2);
      roll = $urandom_range(99);
      case (mode)
        0: op = roll < 40 ? csvl_pkg::OP_APPEND : roll < 45 ? csvl_pkg::OP_DROP :
                roll < 65 ? csvl_pkg::OP_INCREMENT : roll < 80 ? csvl_pkg::OP_DECREMENT :
                roll < 88 ? csvl_pkg::OP_FIND : roll < 96 ? csvl_pkg::OP_READ :
                roll < 97 ? csvl_pkg::OP_CLEAR : OP_UNUSED;
        1: op = roll < 12 ? csvl_pkg::OP_APPEND : roll < 18 ? csvl_pkg::OP_DROP :
                roll < 50 ? csvl_pkg::OP_INCREMENT : roll < 75 ? csvl_pkg::OP_DECREMENT :
                roll < 85 ? csvl_pkg::OP_FIND : roll < 96 ? csvl_pkg::OP_READ :
                roll < 97 ? csvl_pkg::OP_CLEAR : OP_UNUSED;
        default: op = roll < 10 ? csvl_pkg::OP_APPEND : roll < 40 ? csvl_pkg::OP_DROP :
                roll < 60 ? csvl_pkg::OP_INCREMENT : roll < 75 ? csvl_pkg::OP_DECREMENT :
                roll < 85 ? csvl_pkg::OP_FIND : roll < 95 ? csvl_pkg::OP_READ :
                roll < 97 ? csvl_pkg::OP_CLEAR : OP_UNUSED;
      endcase
      if (list_len > 0 && $urandom_range(99) < 85) pos = 7'($urandom_range(list_len - 1));
      else pos = 7'($urandom_range(127));
      if (op == csvl_pkg::OP_FIND && list_len > 0 && $urandom_range(99) < 60)
        val = list_entries[$urandom_range(list_len - 1)].value;
      else
        val = pick_value();
      issue_op(op, pos, val);
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.ok            = m_tdata[0];
      got.found         = m_tdata[1];
      got.entry_value   = m_tdata[17:2];
      got.entry_count   = m_tdata[33:18];
      got.length        = m_tdata[41:34];
      got.largest_value = m_tdata[57:42];
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: %h", m_tdata);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.ok != want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, got.ok);
          mismatch_count++;
        end
        if (got.found != want.found) begin
          $error("found: expected %0d, got %0d", want.found, got.found);
          mismatch_count++;
        end
        if (got.entry_value != want.entry_value) begin
          $error("entry_value: expected %0d, got %0d", want.entry_value, got.entry_value);
          mismatch_count++;
        end
        if (got.entry_count != want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
          mismatch_count++;
        end
        if (got.length != want.length) begin
          $error("length: expected %0d, got %0d", want.length, got.length);
          mismatch_count++;
        end
        if (got.largest_value != want.largest_value) begin
          $error("largest_value: expected %0d, got %0d", want.largest_value,
                 got.largest_value);
          mismatch_count++;
        end
      end
    end
  end

  // main sequence
  initial begin
    stim_row_t    row;
    list_result_t typed_result;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    list_len = 0;
    mismatch_count = 0;
    words_sent = 0;
    results_seen = 0;
    hold_req = 1'b0;
    send_idle_pct = 27;
    recv_idle_pct = 84;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      typed_result = '0;
      typed_result.ok = row.ok;
      typed_result.found = row.found;
      typed_result.length = row.length;
      typed_result.largest_value = row.largest;
      issue_op(row.op, row.pos, row.val, row.typed, typed_result);
    end

    // random, with the receiver backing up the block once
    hold_req = 1'b1;
    random_ops(RANDOM_PER_PHASE);

    // fill the list, overflow it, move an entry across the whole list
    send_idle_pct = 84;
    recv_idle_pct = 27;
    issue_op(csvl_pkg::OP_CLEAR, 7'd0, 16'h0000);
    while (list_len < LIST_DEPTH) issue_op(csvl_pkg::OP_APPEND, 7'd0, pick_value());
    issue_op(csvl_pkg::OP_APPEND, 7'd0, 16'h1234);
    issue_op(csvl_pkg::OP_DECREMENT, 7'd127, 16'h0000);
    issue_op(csvl_pkg::OP_INCREMENT, 7'd0, 16'h0000);
    issue_op(csvl_pkg::OP_READ, 7'd127, 16'h0000);
    issue_op(csvl_pkg::OP_READ, 7'd0, 16'h0000);
    issue_op(csvl_pkg::OP_FIND, 7'd0, list_entries[64].value);
    issue_op(csvl_pkg::OP_DROP, 7'd0, 16'h0000);
    random_ops(RANDOM_PER_PHASE);

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_ops(RANDOM_PER_PHASE);
    s_tvalid <= 1'b0;

    // drain, then give a late word time to show up
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d words, checked %0d result words", words_sent, results_seen);
    $display("covered empty and full list, range errors, unused op, long moves, stalls");
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // watchdog
  initial begin
    #(200_000_000);
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
